/* sv/sapb_pkg.sv */
// Package with the shared types and constants of the serial armed pulse burst block.
`timescale 1ns / 1ps
`default_nettype none

package sapb_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LOW_STEP     = 2'd0,
    CFG_PULSE_PERIOD = 2'd1,
    CFG_BURST_LENGTH = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // Item kinds carried in tuser.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] LOW_STEP_RST     = 8'd5;
  localparam logic [7:0] PULSE_PERIOD_RST = 8'd10;
  localparam logic [15:0] BURST_LENGTH_RST = 16'd1000;

  // Frame patterns: first, second and last byte.
  localparam logic [7:0] CHR_E     = 8'h45;
  localparam logic [7:0] CHR_L     = 8'h4C;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_R     = 8'h52;

  localparam logic [1:0] POS_LAST = 2'd2;

  typedef struct packed {
    logic [7:0]  low_step;
    logic [7:0]  pulse_period;
    logic [15:0] burst_length;
  } cfg_t;

  typedef struct packed {
    logic burst_active;
    logic side_select;
    logic pin_driven;
    logic pin_level;
  } result_t;

endpackage

`default_nettype wire

/* sv/sapb_core.sv */
// Frame decoder, burst state and pulse counters; updates once per enabled item.
`timescale 1ns / 1ps
`default_nettype none

module sapb_core
  import sapb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       cmd_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  logic [1:0]  pos_q, pos_d;
  logic [7:0]  b0_q, b0_d, b1_q, b1_d;
  logic        armed_q, armed_d;
  logic        side_q, side_d;
  logic        active_q, active_d;
  logic        driven_q, driven_d;
  logic        level_q, level_d;
  logic [7:0]  step_q, step_d;
  logic [15:0] tick_q, tick_d;

  logic is_arm, is_left, is_right;

  assign is_arm   = (b0_q == CHR_E) && (b1_q == CHR_L) && (byte_i == CHR_COLON);
  assign is_left  = (b0_q == CHR_L) && (b1_q == CHR_L) && (byte_i == CHR_L);
  assign is_right = (b0_q == CHR_R) && (b1_q == CHR_R) && (byte_i == CHR_R);

  always_comb begin
    pos_d    = pos_q;
    b0_d     = b0_q;
    b1_d     = b1_q;
    armed_d  = armed_q;
    side_d   = side_q;
    active_d = active_q;
    driven_d = driven_q;
    level_d  = level_q;
    step_d   = step_q;
    tick_d   = tick_q;
    if (cmd_i == CMD_BYTE) begin
      unique case (pos_q)
        2'd0: begin
          b0_d  = byte_i;
          pos_d = 2'd1;
        end
        2'd1: begin
          b1_d  = byte_i;
          pos_d = POS_LAST;
        end
        POS_LAST: begin
          if (!armed_q) begin
            if (is_arm) armed_d = 1'b1;
          end else begin
            armed_d = 1'b0;
            if (is_left) side_d = 1'b0;
            else if (is_right) side_d = 1'b1;
            driven_d = 1'b1;
            active_d = 1'b1;
          end
          pos_d = 2'd0;
        end
        default: pos_d = 2'd0;
      endcase
    end else if (active_q) begin
      // The wrap to zero happens before the increment, so a wrapping step lands on one.
      if (step_q == cfg_i.low_step) begin
        level_d = 1'b0;
        step_d  = step_q + 8'd1;
      end else if (step_q >= cfg_i.pulse_period) begin
        level_d = 1'b1;
        step_d  = 8'd1;
      end else begin
        step_d  = step_q + 8'd1;
      end
      if (tick_q >= cfg_i.burst_length) begin
        tick_d   = 16'd1;
        driven_d = 1'b0;
        level_d  = 1'b0;
        active_d = 1'b0;
      end else begin
        tick_d = tick_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 2'd0;
      b0_q     <= 8'd0;
      b1_q     <= 8'd0;
      armed_q  <= 1'b0;
      side_q   <= 1'b0;
      active_q <= 1'b0;
      driven_q <= 1'b0;
      level_q  <= 1'b0;
      step_q   <= 8'd0;
      tick_q   <= 16'd0;
    end else if (en_i) begin
      pos_q    <= pos_d;
      b0_q     <= b0_d;
      b1_q     <= b1_d;
      armed_q  <= armed_d;
      side_q   <= side_d;
      active_q <= active_d;
      driven_q <= driven_d;
      level_q  <= level_d;
      step_q   <= step_d;
      tick_q   <= tick_d;
    end
  end

  // Result shows the state after this item.
  assign res_o.pin_level    = level_d;
  assign res_o.pin_driven   = driven_d;
  assign res_o.side_select  = side_d;
  assign res_o.burst_active = active_d;

endmodule

`default_nettype wire

/* sv/serial_armed_pulse_burst.sv */
// Top level: stream handshake, input and result registers, configuration registers.
// An accepted request waits in the input register, and its result in the result register.
// Throughput: one request per cycle while the result side is ready; the input register
// lets one request be taken while a result waits, then input stalls until that drains.
// Reset (rst_ni low, asynchronous) clears all burst state and both registers' valid
// flags and loads the configuration defaults 5, 10 and 1000.
`timescale 1ns / 1ps
`default_nettype none

module serial_armed_pulse_burst
  import sapb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] pin_level, [1] pin_driven, [2] side_select, [3] burst_active, [7:4] zero
  output logic [7:0]       m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    in_vld_q;
  logic    in_cmd_q;
  logic [7:0] in_byte_q;
  logic    out_vld_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_step     <= LOW_STEP_RST;
      cfg_q.pulse_period <= PULSE_PERIOD_RST;
      cfg_q.burst_length <= BURST_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_STEP:     cfg_q.low_step     <= cfg_data_i[7:0];
        CFG_PULSE_PERIOD: cfg_q.pulse_period <= cfg_data_i[7:0];
        CFG_BURST_LENGTH: cfg_q.burst_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The buffered request moves into the result register when that is free or drained.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (advance) out_q <= res;
  end

  sapb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cmd_i  (in_cmd_q),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_q};

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the serial armed pulse burst block.
`timescale 1ns / 1ps

module tb;
  import sapb_pkg::*;

  localparam int  WATCHDOG_LIMIT = 1000;
  localparam int  PHASES         = 8;
  localparam int  PHASE_ITEMS    = 50;
  localparam logic SIDE_LEFT     = 1'b0;
  localparam logic SIDE_RIGHT    = 1'b1;

  // Tracks the pin state that each accepted request should produce and checks
  // the results against it in order.
  class pin_state_board;
    cfg_t       cfg;
    bit [1:0]   position;
    bit [7:0]   held [2];
    bit         armed;
    bit         side;
    bit         active;
    bit         driven;
    bit         level;
    bit [7:0]   step;
    bit [15:0]  ticks;
    result_t    due [$];
    int         mismatches;

    function new();
      cfg.low_step     = LOW_STEP_RST;
      cfg.pulse_period = PULSE_PERIOD_RST;
      cfg.burst_length = BURST_LENGTH_RST;
    endfunction

    function void write_register(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_LOW_STEP:     cfg.low_step = value[7:0];
        CFG_PULSE_PERIOD: cfg.pulse_period = value[7:0];
        CFG_BURST_LENGTH: cfg.burst_length = value;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] rx);
      if (position < POS_LAST) begin
        held[position[0]] = rx;
        position++;
      end else begin
        if (!armed) begin
          if (held[0] == CHR_E && held[1] == CHR_L && rx == CHR_COLON) armed = 1'b1;
        end else begin
          // Any complete frame after the arming frame starts a burst.
          armed = 1'b0;
          if (held[0] == CHR_L && held[1] == CHR_L && rx == CHR_L) side = SIDE_LEFT;
          else if (held[0] == CHR_R && held[1] == CHR_R && rx == CHR_R) side = SIDE_RIGHT;
          driven = 1'b1;
          active = 1'b1;
        end
        position = '0;
      end
    endfunction

    function void take_tick();
      if (!active) return;
      if (step == cfg.low_step) begin
        level = 1'b0;
      end else if (step >= cfg.pulse_period) begin
        step  = '0;
        level = 1'b1;
      end
      step++;
      if (ticks >= cfg.burst_length) begin
        ticks  = '0;
        driven = 1'b0;
        level  = 1'b0;
        active = 1'b0;
      end
      ticks++;
    endfunction

    function void note_request(logic cmd, logic [7:0] rx);
      result_t r;
      if (cmd == CMD_BYTE) take_byte(rx);
      else take_tick();
      r.pin_level    = level;
      r.pin_driven   = driven;
      r.side_select  = side;
      r.burst_active = active;
      due.push_back(r);
    endfunction

    function void compare(string what, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_pin_state(logic [7:0] tdata);
      result_t got, want;
      got = result_t'(tdata[3:0]);
      if (due.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, tdata);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare("pin_level", 4'(want.pin_level), 4'(got.pin_level));
      compare("pin_driven", 4'(want.pin_driven), 4'(got.pin_driven));
      compare("side_select", 4'(want.side_select), 4'(got.side_select));
      compare("burst_active", 4'(want.burst_active), 4'(got.burst_active));
      compare("padding", 4'b0, tdata[7:4]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  pin_state_board board;
  bit             calm;
  int             hold_request;
  int             items_sent;
  int             quiet_cycles;

  serial_armed_pulse_burst u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random short stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left == 0 && stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      m_axis_tready = (hold_left == 0 && stall_left == 0);
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_pin_state(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] rx);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = rx;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(cmd, rx);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    send_item(CMD_BYTE, b0);
    send_item(CMD_BYTE, b1);
    send_item(CMD_BYTE, b2);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stops sending and waits until every pending result has been checked.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // The upper byte of the 8-bit registers' data is random and must be ignored.
  task automatic configure(input logic [7:0] low, input logic [7:0] period,
                           input logic [15:0] length);
    write_register(CFG_LOW_STEP, {8'($urandom_range(0, 255)), low});
    write_register(CFG_PULSE_PERIOD, {8'($urandom_range(0, 255)), period});
    write_register(CFG_BURST_LENGTH, length);
  endtask

  task automatic start_burst();
    while (board.position != 0) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    send_frame(CHR_E, CHR_L, CHR_COLON);
    if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 4));
    case ($urandom_range(0, 3))
      0: send_frame(CHR_L, CHR_L, CHR_L);
      1: send_frame(CHR_R, CHR_R, CHR_R);
      2: send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      default: send_frame(CHR_R, 8'h00, CHR_R);
    endcase
  endtask

  task automatic random_requests(input int budget);
    int stop_at;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        start_burst();
        send_ticks($urandom_range(1, 30));
      end else if (pick < 70) begin
        send_ticks($urandom_range(1, 12));
      end else if (pick < 85) begin
        send_item(CMD_BYTE, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end else begin
        // Near misses: frames that almost arm or almost select a side, or a lone E byte.
        case ($urandom_range(0, 2))
          0: send_frame(CHR_E, CHR_L, 8'($urandom_range(0, 255)));
          1: send_frame(CHR_L, CHR_L, CHR_R);
          default: send_item(CMD_BYTE, CHR_E);
        endcase
      end
    end
  endtask

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_BYTE;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_LOW_STEP;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset configuration.
    send_ticks(2);
    send_frame(8'h00, 8'h00, 8'h00);
    send_frame(CHR_E, CHR_L, CHR_COLON);
    send_frame(CHR_L, CHR_L, CHR_L);
    send_ticks(7);
    // A second start frame while the burst runs switches the side only.
    send_frame(CHR_E, CHR_L, CHR_COLON);
    send_frame(CHR_R, CHR_R, CHR_R);
    send_ticks(2);
    send_frame(8'hFF, CHR_L, 8'h00);
    settle();

    write_register(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(8'd0, 8'd0, 16'd0);
        1: configure(8'd255, 8'd255, 16'd65535);
        2: configure(8'd2, 8'd6, 16'd25);
        3: configure(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                     16'($urandom_range(0, 60)));
        4: configure(8'd12, 8'd4, 16'd30);
        5: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 100)));
        6: configure(8'd0, 8'd255, 16'd65535);
        default: configure(8'($urandom_range(1, 8)), 8'($urandom_range(2, 12)),
                           16'($urandom_range(5, 40)));
      endcase
      if (phase == 1) begin
        // Long enough for the step counter to pass the top of its range.
        start_burst();
        send_ticks(260);
      end
      if (phase == 2) hold_request = 60;
      if (phase == PHASES - 1) calm = 1'b1;
      random_requests(PHASE_ITEMS);
      settle();
    end

    if (board.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sapb_pkg.sv
sv/sapb_core.sv
sv/serial_armed_pulse_burst.sv
sim/tb.sv
